// ===== design/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the multilevel feedback scheduler
// Holds parameter defaults, field widths, result codes and the controller
// state and command types.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int SLOTS_DEF  = 16;
	localparam int LEVELS_DEF = 8;

	localparam int TAG_W = 8;
	localparam int SVC_W = 16;
	localparam int QNT_W = 8;
	localparam int STA_W = 2;
	localparam int RLV_W = 3;

	localparam logic [QNT_W-1:0] QUANTUM_RESET = 8'd1;
	localparam logic [QNT_W-1:0] QCOUNT_MAX    = 8'd255;

	// result status codes
	localparam logic [STA_W-1:0] STATUS_IDLE   = 2'd0;
	localparam logic [STA_W-1:0] STATUS_RAN    = 2'd1;
	localparam logic [STA_W-1:0] STATUS_ADMIT  = 2'd2;
	localparam logic [STA_W-1:0] STATUS_REJECT = 2'd3;

	// input command codes
	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADMIT,
		ST_PREEMPT,
		ST_DISPATCH,
		ST_RUN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input fields
		logic admit;     // admit step
		logic preempt;   // preemption check step
		logic dispatch;  // pick process and read its slot
		logic run;       // run one tick and deliver result
	} ctl_t;

endpackage

// ===== design/mfs_controller.sv =====
// ----------------------------------------------------------------------------
// mfs_controller: sequencer of the scheduler
// Steps an admit through the admit state and a tick through the preempt,
// dispatch and run states, issuing one command per cycle to the datapath while a transaction is in progress.
// ----------------------------------------------------------------------------
module mfs_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cmd,
	output logic          busy,
	output mfs_pkg::ctl_t ctl
);

	mfs_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		unique case (state_q)
			mfs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = (cmd == mfs_pkg::CMD_ADMIT) ? mfs_pkg::ST_ADMIT
					                                       : mfs_pkg::ST_PREEMPT;
				end
			end
			mfs_pkg::ST_ADMIT: begin
				ctl.admit = 1'b1;
				state_d   = mfs_pkg::ST_IDLE;
			end
			mfs_pkg::ST_PREEMPT: begin
				ctl.preempt = 1'b1;
				state_d     = mfs_pkg::ST_DISPATCH;
			end
			mfs_pkg::ST_DISPATCH: begin
				ctl.dispatch = 1'b1;
				state_d      = mfs_pkg::ST_RUN;
			end
			mfs_pkg::ST_RUN: begin
				ctl.run = 1'b1;
				state_d = mfs_pkg::ST_IDLE;
			end
			default: begin
				state_d = mfs_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not make block busy");
	a_preempt_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfs_pkg::ST_PREEMPT) |=> (state_q == mfs_pkg::ST_DISPATCH))
		else $error("preempt step not followed by dispatch");
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfs_pkg::ST_RUN || state_q == mfs_pkg::ST_ADMIT)
		|=> (state_q == mfs_pkg::ST_IDLE))
		else $error("result step not followed by idle");
`endif

endmodule

// ===== design/mfs_datapath.sv =====
// ----------------------------------------------------------------------------
// mfs_datapath: slot memories, level queues and processor state
// Slot fields live in memories with registered reads; level queues are
// linked lists through the slot link memory.
// ----------------------------------------------------------------------------
module mfs_datapath #(
	parameter int SLOTS  = mfs_pkg::SLOTS_DEF,
	parameter int LEVELS = mfs_pkg::LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mfs_pkg::ctl_t              ctl,
	input  logic [mfs_pkg::TAG_W-1:0]  proc_tag,
	input  logic [mfs_pkg::SVC_W-1:0]  service_ticks,
	input  logic                       cfg_valid,
	input  logic [mfs_pkg::QNT_W-1:0]  cfg_data,
	output logic                       done,
	output logic [mfs_pkg::STA_W-1:0]  status,
	output logic [mfs_pkg::TAG_W-1:0]  run_tag,
	output logic [mfs_pkg::RLV_W-1:0]  run_level,
	output logic                       finished
);

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(LEVELS);
	localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

	// slot memories
	logic [mfs_pkg::TAG_W-1:0] tag_mem  [SLOTS];
	logic [mfs_pkg::SVC_W-1:0] rem_mem  [SLOTS];
	logic [LW-1:0]             lvl_mem  [SLOTS];
	logic [SW-1:0]             link_mem [SLOTS];

	logic [mfs_pkg::TAG_W-1:0] rd_tag;
	logic [mfs_pkg::SVC_W-1:0] rd_rem;
	logic [LW-1:0]             rd_lvl;
	logic [SW-1:0]             rd_link;

	// queue and processor state
	logic [SLOTS-1:0]  used_q;
	logic [LEVELS-1:0] nonempty_q;
	logic [SW-1:0]     head_q [LEVELS];
	logic [SW-1:0]     tail_q [LEVELS];
	logic              cpu_busy_q;
	logic [SW-1:0]     cpu_slot_q;
	logic [LW-1:0]     cur_level_q;
	logic [mfs_pkg::QNT_W-1:0] qcount_q;
	logic [mfs_pkg::QNT_W-1:0] quantum_q;
	logic [mfs_pkg::TAG_W-1:0] tag_q;
	logic [mfs_pkg::SVC_W-1:0] svc_q;
	logic              popped_q;
	logic              pop_more_q;
	logic [LW-1:0]     pop_lvl_q;

	// search results
	logic          free_ok;
	logic [SW-1:0] free_idx;
	logic          any_ready;
	logic [LW-1:0] top_lvl;

	// lowest free slot
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_ok  = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// highest priority non-empty level
	always_comb begin
		any_ready = 1'b0;
		top_lvl   = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				any_ready = 1'b1;
				top_lvl   = LW'(i);
			end
		end
	end

	// step decisions
	logic          preempt_go;
	logic          pop_go;
	logic [SW-1:0] rd_addr;
	logic [mfs_pkg::QNT_W-1:0] qcount_inc;
	logic          run_fin;
	logic          demote;
	logic [LW-1:0] lvl_new;

	always_comb begin
		preempt_go = ctl.preempt && cpu_busy_q && any_ready && (top_lvl < cur_level_q);
		pop_go     = ctl.dispatch && !cpu_busy_q && any_ready;
		rd_addr    = pop_go ? head_q[top_lvl] : cpu_slot_q;
		qcount_inc = (qcount_q == mfs_pkg::QCOUNT_MAX) ? qcount_q : qcount_q + 1'b1;
		run_fin    = (rd_rem <= mfs_pkg::SVC_W'(1));
		demote     = !run_fin && (qcount_inc >= quantum_q);
		lvl_new    = (rd_lvl == LVL_LAST) ? rd_lvl : rd_lvl + 1'b1;
	end

	// tail push request
	logic          push_en;
	logic [LW-1:0] push_lvl;
	logic [SW-1:0] push_slot;

	always_comb begin
		push_en   = 1'b0;
		push_lvl  = '0;
		push_slot = cpu_slot_q;
		if (ctl.admit && free_ok) begin
			push_en   = 1'b1;
			push_slot = free_idx;
		end else if (preempt_go) begin
			push_en  = 1'b1;
			push_lvl = cur_level_q;
		end else if (ctl.run && cpu_busy_q && demote) begin
			push_en  = 1'b1;
			push_lvl = lvl_new;
		end
	end

	// slot field writes and registered reads
	always_ff @(posedge clk) begin
		if (ctl.admit && free_ok) begin
			tag_mem[free_idx] <= tag_q;
			rem_mem[free_idx] <= svc_q;
			lvl_mem[free_idx] <= '0;
		end else if (ctl.run && cpu_busy_q) begin
			rem_mem[cpu_slot_q] <= run_fin ? '0 : rd_rem - 1'b1;
			if (demote) begin
				lvl_mem[cpu_slot_q] <= lvl_new;
			end
		end
		if (push_en && nonempty_q[push_lvl]) begin
			link_mem[tail_q[push_lvl]] <= push_slot;
		end
		if (ctl.dispatch) begin
			rd_tag  <= tag_mem[rd_addr];
			rd_rem  <= rem_mem[rd_addr];
			rd_lvl  <= lvl_mem[rd_addr];
			rd_link <= link_mem[rd_addr];
		end
	end

	// queue heads and tails, payload of the lists
	always_ff @(posedge clk) begin
		if (ctl.run && popped_q && pop_more_q) begin
			head_q[pop_lvl_q] <= rd_link;
		end
		if (push_en) begin
			tail_q[push_lvl] <= push_slot;
			if (!nonempty_q[push_lvl]) begin
				head_q[push_lvl] <= push_slot;
			end
		end
		if (ctl.load) begin
			tag_q <= proc_tag;
			svc_q <= service_ticks;
		end
		if (pop_go) begin
			pop_lvl_q  <= top_lvl;
			pop_more_q <= (head_q[top_lvl] != tail_q[top_lvl]);
		end
		if (ctl.run) begin
			cur_level_q <= rd_lvl;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			nonempty_q <= '0;
			cpu_busy_q <= 1'b0;
			cpu_slot_q <= '0;
			qcount_q   <= '0;
			quantum_q  <= mfs_pkg::QUANTUM_RESET;
			popped_q   <= 1'b0;
			done       <= 1'b0;
			status     <= mfs_pkg::STATUS_IDLE;
			run_tag    <= '0;
			run_level  <= '0;
			finished   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				quantum_q <= cfg_data;
			end
			if (ctl.dispatch) begin
				popped_q <= pop_go;
				if (pop_go) begin
					if (head_q[top_lvl] == tail_q[top_lvl]) begin
						nonempty_q[top_lvl] <= 1'b0;
					end
					cpu_slot_q <= head_q[top_lvl];
					cpu_busy_q <= 1'b1;
					qcount_q   <= '0;
				end
			end
			if (preempt_go) begin
				cpu_busy_q <= 1'b0;
				qcount_q   <= '0;
			end
			if (push_en) begin
				nonempty_q[push_lvl] <= 1'b1;
			end
			// admit result
			if (ctl.admit) begin
				done      <= 1'b1;
				run_tag   <= tag_q;
				run_level <= '0;
				finished  <= 1'b0;
				status    <= free_ok ? mfs_pkg::STATUS_ADMIT : mfs_pkg::STATUS_REJECT;
				if (free_ok) begin
					used_q[free_idx] <= 1'b1;
				end
			end
			// tick result
			if (ctl.run) begin
				done <= 1'b1;
				if (cpu_busy_q) begin
					status    <= mfs_pkg::STATUS_RAN;
					run_tag   <= rd_tag;
					run_level <= mfs_pkg::RLV_W'(32'(rd_lvl));
					finished  <= run_fin;
					qcount_q  <= qcount_inc;
					if (run_fin) begin
						used_q[cpu_slot_q] <= 1'b0;
						cpu_busy_q         <= 1'b0;
					end else if (demote) begin
						cpu_busy_q <= 1'b0;
					end
				end else begin
					status    <= mfs_pkg::STATUS_IDLE;
					run_tag   <= '0;
					run_level <= '0;
					finished  <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/multilevel_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler: multilevel feedback queue scheduler
// Admits processes into level 0 and runs one tick per tick command.
// ----------------------------------------------------------------------------
// Each transaction starts when start is high and busy is low. An admit goes
// through the admit step to its result, a tick through the preempt check,
// the dispatch with the slot memory read and the run step. The result
// appears for one cycle with done high and must be taken then; the receiver
// cannot stall. The quantum register may be written at any time through
// cfg_valid (cfg_ready is always high), but only while busy is low if the
// write is to apply cleanly to the next transaction.
module multilevel_feedback_scheduler #(
	parameter int SLOTS  = mfs_pkg::SLOTS_DEF,
	parameter int LEVELS = mfs_pkg::LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [mfs_pkg::TAG_W-1:0]  proc_tag,
	input  logic [mfs_pkg::SVC_W-1:0]  service_ticks,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mfs_pkg::QNT_W-1:0]  cfg_data,
	output logic                       done,
	output logic [mfs_pkg::STA_W-1:0]  status,
	output logic [mfs_pkg::TAG_W-1:0]  run_tag,
	output logic [mfs_pkg::RLV_W-1:0]  run_level,
	output logic                       finished
);

	mfs_pkg::ctl_t ctl;

	assign cfg_ready = 1'b1;

	mfs_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl)
	);

	mfs_datapath #(
		.SLOTS  (SLOTS),
		.LEVELS (LEVELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.proc_tag      (proc_tag),
		.service_ticks (service_ticks),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.run_tag       (run_tag),
		.run_level     (run_level),
		.finished      (finished)
	);

endmodule
